@@ rtl/kalman_position_accel_fusion_unit_macros.svh @@
// Assertion macros used by the port-level assertion module of the fusion unit.
`ifndef KALMAN_POSITION_ACCEL_FUSION_UNIT_MACROS_SVH
`define KALMAN_POSITION_ACCEL_FUSION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KPAF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KPAF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kpaf_pkg.sv @@
// ----------------------------------------------------------------------------
// kpaf_pkg
// Types, constants, scratch memory map and micro-program of the fusion unit.
// ----------------------------------------------------------------------------
package kpaf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 36;
    localparam int ADDR_W    = 6;
    localparam int MEM_DEPTH = 64;
    localparam int PC_W      = 8;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int DVD_W     = DATA_W + FRAC_BITS;

    localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] FX_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [2:0] cfg_idx_t;
    typedef logic [NUM_CFG-1:0][DATA_W-1:0] cfg_array_t;

    typedef struct packed {
        logic signed [31:0] meas_position;
        logic signed [31:0] meas_accel;
        logic [15:0]        time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] est_position;
        logic signed [31:0] est_velocity;
        logic signed [31:0] est_accel;
        logic               singular_flag;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_Q_POS  = 3'd0;
    localparam cfg_idx_t CFG_Q_VEL  = 3'd1;
    localparam cfg_idx_t CFG_Q_ACC  = 3'd2;
    localparam cfg_idx_t CFG_R_POS  = 3'd3;
    localparam cfg_idx_t CFG_R_ACC  = 3'd4;
    localparam cfg_idx_t CFG_P0_POS = 3'd5;
    localparam cfg_idx_t CFG_P0_VEL = 3'd6;
    localparam cfg_idx_t CFG_P0_ACC = 3'd7;

    // Scratch memory map.
    localparam addr_t A_S0   = 6'd0;
    localparam addr_t A_S1   = 6'd1;
    localparam addr_t A_S2   = 6'd2;
    localparam addr_t A_P00  = 6'd3;
    localparam addr_t A_P01  = 6'd4;
    localparam addr_t A_P02  = 6'd5;
    localparam addr_t A_P11  = 6'd6;
    localparam addr_t A_P12  = 6'd7;
    localparam addr_t A_P22  = 6'd8;
    localparam addr_t A_DT   = 6'd9;
    localparam addr_t A_H    = 6'd10;
    localparam addr_t A_ZP   = 6'd11;
    localparam addr_t A_ZA   = 6'd12;
    localparam addr_t A_XP0  = 6'd13;
    localparam addr_t A_XP1  = 6'd14;
    localparam addr_t A_XP2  = 6'd15;
    localparam addr_t A_A00  = 6'd16;
    localparam addr_t A_A01  = 6'd17;
    localparam addr_t A_A02  = 6'd18;
    localparam addr_t A_A11  = 6'd19;
    localparam addr_t A_A12  = 6'd20;
    localparam addr_t A_PP00 = 6'd21;
    localparam addr_t A_PP01 = 6'd22;
    localparam addr_t A_PP02 = 6'd23;
    localparam addr_t A_PP11 = 6'd24;
    localparam addr_t A_PP12 = 6'd25;
    localparam addr_t A_PP22 = 6'd26;
    localparam addr_t A_S00  = 6'd27;
    localparam addr_t A_S11  = 6'd28;
    localparam addr_t A_DET  = 6'd29;
    localparam addr_t A_IN0  = 6'd30;
    localparam addr_t A_IN1  = 6'd31;
    localparam addr_t A_N0   = 6'd32;
    localparam addr_t A_N1   = 6'd33;
    localparam addr_t A_K00  = 6'd34;
    localparam addr_t A_K01  = 6'd35;
    localparam addr_t A_K02  = 6'd36;
    localparam addr_t A_K10  = 6'd37;
    localparam addr_t A_K11  = 6'd38;
    localparam addr_t A_K12  = 6'd39;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MAC, OP_MSB, OP_ADDC, OP_ST, OP_DIV, OP_BZ, OP_END
    } op_t;

    typedef struct packed {
        op_t             op;
        logic            clr;
        addr_t           a;
        addr_t           b;
        logic [PC_W-1:0] d;
    } uop_t;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_FETCH, S_OPA, S_OPB, S_MUL, S_DIV, S_DONE
    } core_state_t;

    localparam logic [PC_W-1:0] PC_SING = 8'd123;

    function automatic uop_t u_mk(input op_t op, input logic clr, input addr_t a,
                                  input addr_t b, input logic [PC_W-1:0] d);
        uop_t u;
        u.op  = op;
        u.clr = clr;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        return u;
    endfunction

    function automatic uop_t u_add(input logic clr, input addr_t a);
        return u_mk(OP_ADD, clr, a, a, '0);
    endfunction

    function automatic uop_t u_sub(input addr_t a);
        return u_mk(OP_SUB, 1'b0, a, a, '0);
    endfunction

    function automatic uop_t u_mac(input logic clr, input addr_t a, input addr_t b);
        return u_mk(OP_MAC, clr, a, b, '0);
    endfunction

    function automatic uop_t u_msb(input addr_t a, input addr_t b);
        return u_mk(OP_MSB, 1'b0, a, b, '0);
    endfunction

    function automatic uop_t u_addc(input logic clr, input cfg_idx_t idx);
        return u_mk(OP_ADDC, clr, {3'b000, idx}, '0, '0);
    endfunction

    function automatic uop_t u_st(input addr_t d);
        return u_mk(OP_ST, 1'b0, '0, '0, {2'b00, d});
    endfunction

    function automatic uop_t u_div(input addr_t a, input addr_t d);
        return u_mk(OP_DIV, 1'b0, a, A_DET, {2'b00, d});
    endfunction

    function automatic uop_t u_bz(input addr_t a, input logic [PC_W-1:0] target);
        return u_mk(OP_BZ, 1'b0, a, a, target);
    endfunction

    function automatic uop_t u_end();
        return u_mk(OP_END, 1'b0, '0, '0, '0);
    endfunction

    // Micro-program of one filter step. The singular branch starts at PC_SING.
    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // Predicted state.
            8'd0:   u = u_add(1'b1, A_S0);
            8'd1:   u = u_mac(1'b0, A_DT, A_S1);
            8'd2:   u = u_mac(1'b0, A_H, A_S2);
            8'd3:   u = u_st(A_XP0);
            8'd4:   u = u_add(1'b1, A_S1);
            8'd5:   u = u_mac(1'b0, A_DT, A_S2);
            8'd6:   u = u_st(A_XP1);
            8'd7:   u = u_add(1'b1, A_S2);
            8'd8:   u = u_st(A_XP2);
            // Transition times covariance.
            8'd9:   u = u_add(1'b1, A_P00);
            8'd10:  u = u_mac(1'b0, A_DT, A_P01);
            8'd11:  u = u_mac(1'b0, A_H, A_P02);
            8'd12:  u = u_st(A_A00);
            8'd13:  u = u_add(1'b1, A_P01);
            8'd14:  u = u_mac(1'b0, A_DT, A_P11);
            8'd15:  u = u_mac(1'b0, A_H, A_P12);
            8'd16:  u = u_st(A_A01);
            8'd17:  u = u_add(1'b1, A_P02);
            8'd18:  u = u_mac(1'b0, A_DT, A_P12);
            8'd19:  u = u_mac(1'b0, A_H, A_P22);
            8'd20:  u = u_st(A_A02);
            8'd21:  u = u_add(1'b1, A_P11);
            8'd22:  u = u_mac(1'b0, A_DT, A_P12);
            8'd23:  u = u_st(A_A11);
            8'd24:  u = u_add(1'b1, A_P12);
            8'd25:  u = u_mac(1'b0, A_DT, A_P22);
            8'd26:  u = u_st(A_A12);
            // Predicted covariance, upper triangle.
            8'd27:  u = u_addc(1'b1, CFG_Q_POS);
            8'd28:  u = u_add(1'b0, A_A00);
            8'd29:  u = u_mac(1'b0, A_A01, A_DT);
            8'd30:  u = u_mac(1'b0, A_A02, A_H);
            8'd31:  u = u_st(A_PP00);
            8'd32:  u = u_add(1'b1, A_A01);
            8'd33:  u = u_mac(1'b0, A_A02, A_DT);
            8'd34:  u = u_st(A_PP01);
            8'd35:  u = u_add(1'b1, A_A02);
            8'd36:  u = u_st(A_PP02);
            8'd37:  u = u_addc(1'b1, CFG_Q_VEL);
            8'd38:  u = u_add(1'b0, A_A11);
            8'd39:  u = u_mac(1'b0, A_A12, A_DT);
            8'd40:  u = u_st(A_PP11);
            8'd41:  u = u_add(1'b1, A_A12);
            8'd42:  u = u_st(A_PP12);
            8'd43:  u = u_addc(1'b1, CFG_Q_ACC);
            8'd44:  u = u_add(1'b0, A_P22);
            8'd45:  u = u_st(A_PP22);
            // Innovation covariance and its determinant.
            8'd46:  u = u_add(1'b1, A_PP00);
            8'd47:  u = u_addc(1'b0, CFG_R_POS);
            8'd48:  u = u_st(A_S00);
            8'd49:  u = u_add(1'b1, A_PP22);
            8'd50:  u = u_addc(1'b0, CFG_R_ACC);
            8'd51:  u = u_st(A_S11);
            8'd52:  u = u_mac(1'b1, A_S00, A_S11);
            8'd53:  u = u_msb(A_PP02, A_PP02);
            8'd54:  u = u_st(A_DET);
            8'd55:  u = u_bz(A_DET, PC_SING);
            // Innovations.
            8'd56:  u = u_add(1'b1, A_ZP);
            8'd57:  u = u_sub(A_XP0);
            8'd58:  u = u_st(A_IN0);
            8'd59:  u = u_add(1'b1, A_ZA);
            8'd60:  u = u_sub(A_XP2);
            8'd61:  u = u_st(A_IN1);
            // Gain, one row at a time.
            8'd62:  u = u_mac(1'b1, A_PP00, A_S11);
            8'd63:  u = u_msb(A_PP02, A_PP02);
            8'd64:  u = u_st(A_N0);
            8'd65:  u = u_mac(1'b1, A_PP02, A_S00);
            8'd66:  u = u_msb(A_PP00, A_PP02);
            8'd67:  u = u_st(A_N1);
            8'd68:  u = u_div(A_N0, A_K00);
            8'd69:  u = u_div(A_N1, A_K10);
            8'd70:  u = u_mac(1'b1, A_PP01, A_S11);
            8'd71:  u = u_msb(A_PP12, A_PP02);
            8'd72:  u = u_st(A_N0);
            8'd73:  u = u_mac(1'b1, A_PP12, A_S00);
            8'd74:  u = u_msb(A_PP01, A_PP02);
            8'd75:  u = u_st(A_N1);
            8'd76:  u = u_div(A_N0, A_K01);
            8'd77:  u = u_div(A_N1, A_K11);
            8'd78:  u = u_mac(1'b1, A_PP02, A_S11);
            8'd79:  u = u_msb(A_PP22, A_PP02);
            8'd80:  u = u_st(A_N0);
            8'd81:  u = u_mac(1'b1, A_PP22, A_S00);
            8'd82:  u = u_msb(A_PP02, A_PP02);
            8'd83:  u = u_st(A_N1);
            8'd84:  u = u_div(A_N0, A_K02);
            8'd85:  u = u_div(A_N1, A_K12);
            // Corrected state.
            8'd86:  u = u_add(1'b1, A_XP0);
            8'd87:  u = u_mac(1'b0, A_K00, A_IN0);
            8'd88:  u = u_mac(1'b0, A_K10, A_IN1);
            8'd89:  u = u_st(A_S0);
            8'd90:  u = u_add(1'b1, A_XP1);
            8'd91:  u = u_mac(1'b0, A_K01, A_IN0);
            8'd92:  u = u_mac(1'b0, A_K11, A_IN1);
            8'd93:  u = u_st(A_S1);
            8'd94:  u = u_add(1'b1, A_XP2);
            8'd95:  u = u_mac(1'b0, A_K02, A_IN0);
            8'd96:  u = u_mac(1'b0, A_K12, A_IN1);
            8'd97:  u = u_st(A_S2);
            // Corrected covariance.
            8'd98:  u = u_add(1'b1, A_PP00);
            8'd99:  u = u_msb(A_K00, A_PP00);
            8'd100: u = u_msb(A_K10, A_PP02);
            8'd101: u = u_st(A_P00);
            8'd102: u = u_add(1'b1, A_PP01);
            8'd103: u = u_msb(A_K00, A_PP01);
            8'd104: u = u_msb(A_K10, A_PP12);
            8'd105: u = u_st(A_P01);
            8'd106: u = u_add(1'b1, A_PP02);
            8'd107: u = u_msb(A_K00, A_PP02);
            8'd108: u = u_msb(A_K10, A_PP22);
            8'd109: u = u_st(A_P02);
            8'd110: u = u_add(1'b1, A_PP11);
            8'd111: u = u_msb(A_K01, A_PP01);
            8'd112: u = u_msb(A_K11, A_PP12);
            8'd113: u = u_st(A_P11);
            8'd114: u = u_add(1'b1, A_PP12);
            8'd115: u = u_msb(A_K01, A_PP02);
            8'd116: u = u_msb(A_K11, A_PP22);
            8'd117: u = u_st(A_P12);
            8'd118: u = u_add(1'b1, A_PP22);
            8'd119: u = u_msb(A_K02, A_PP02);
            8'd120: u = u_msb(A_K12, A_PP22);
            8'd121: u = u_st(A_P22);
            8'd122: u = u_end();
            // Singular innovation: keep the prediction.
            8'd123: u = u_add(1'b1, A_XP0);
            8'd124: u = u_st(A_S0);
            8'd125: u = u_add(1'b1, A_XP1);
            8'd126: u = u_st(A_S1);
            8'd127: u = u_add(1'b1, A_XP2);
            8'd128: u = u_st(A_S2);
            8'd129: u = u_add(1'b1, A_PP00);
            8'd130: u = u_st(A_P00);
            8'd131: u = u_add(1'b1, A_PP01);
            8'd132: u = u_st(A_P01);
            8'd133: u = u_add(1'b1, A_PP02);
            8'd134: u = u_st(A_P02);
            8'd135: u = u_add(1'b1, A_PP11);
            8'd136: u = u_st(A_P11);
            8'd137: u = u_add(1'b1, A_PP12);
            8'd138: u = u_st(A_P12);
            8'd139: u = u_add(1'b1, A_PP22);
            8'd140: u = u_st(A_P22);
            default: u = u_end();
        endcase
        return u;
    endfunction

    // Saturate a wide accumulator to the signed 32 bit range.
    function automatic logic [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] vmax;
        logic signed [ACC_W-1:0] vmin;
        vmax = ACC_W'(64'sh7FFF_FFFF);
        vmin = ACC_W'(-64'sh8000_0000);
        if (v > vmax) begin
            return 32'h7FFF_FFFF;
        end
        if (v < vmin) begin
            return 32'h8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // Round half up to FRAC_BITS fraction bits and saturate.
    function automatic logic [DATA_W-1:0] fx_round(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + FX_HALF) >>> FRAC_BITS;
        if (r > 64'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        if (r < -64'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/kalman_position_accel_fusion_unit.sv @@
// Each input transaction is processed to completion before the next one is accepted: the
// input stalls until the core hands its result to the output register. A singular
// innovation covariance skips the gain and correction steps, and the first item after
// reset also loads the initial state; the regular path runs six gain divisions.
// Reset clears control state; configuration returns to 1.0 and the first item reloads P.
// ----------------------------------------------------------------------------
// kalman_position_accel_fusion_unit
// Three-state Kalman filter fusing barometric position and acceleration.
// ----------------------------------------------------------------------------
module kalman_position_accel_fusion_unit
    import kpaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_array_t   cfg;
    core_status_t status;
    out_item_t    result;
    logic         out_free;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_data_reg, out_data_next;

    kpaf_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kpaf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && !in_stall),
        .item     (in_data),
        .cfg      (cfg),
        .out_free (out_free),
        .status   (status),
        .result   (result)
    );

    // The output register frees up in the same cycle its transaction completes.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign in_stall  = !status.idle;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/kpaf_regs.sv @@
// ----------------------------------------------------------------------------
// kpaf_regs
// Configuration registers: noise variances and initial covariance diagonal.
// ----------------------------------------------------------------------------
module kpaf_regs
    import kpaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    output cfg_array_t           cfg
);

    cfg_array_t cfg_reg;
    cfg_array_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        // Indexes beyond the register list are dropped.
        if (wr_en && (wr_index < CFG_IDX_W'(NUM_CFG)))
        begin
            cfg_next[wr_index[2:0]] = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {NUM_CFG{FX_ONE}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/kpaf_div.sv @@
// ----------------------------------------------------------------------------
// kpaf_div
// Radix-2 restoring divider for the gain: sat(trunc(n * 2^FRAC_BITS / det)).
// ----------------------------------------------------------------------------
module kpaf_div
    import kpaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [DVD_W-1:0] Q_LIM = DVD_W'(64'h8000_0000);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] dm_reg, dm_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] q_reg, q_next;

    logic [DATA_W-1:0] n_mag;
    logic [DATA_W-1:0] d_mag;
    logic [DATA_W:0]   rem_shift;
    logic              q_bit;
    logic [DVD_W-1:0]  q_mag;

    always_comb
    begin
        n_mag = dividend[DATA_W-1] ? (~dividend + 32'd1) : dividend;
        d_mag = divisor[DATA_W-1] ? (~divisor + 32'd1) : divisor;
        rem_shift = {rem_reg[DATA_W-1:0], dvd_reg[DVD_W-1]};
        q_bit = (rem_shift >= {1'b0, dm_reg});
        q_mag = {dvd_reg[DVD_W-2:0], q_bit};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = {n_mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dm_next   = d_mag;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? (rem_shift - {1'b0, dm_reg}) : rem_shift;
            dvd_next = q_mag;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    q_next = (q_mag > Q_LIM) ? 32'h8000_0000 : (~q_mag[DATA_W-1:0] + 32'd1);
                end
                else
                begin
                    q_next = (q_mag >= Q_LIM) ? 32'h7FFF_FFFF : q_mag[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/kpaf_core.sv @@
// ----------------------------------------------------------------------------
// kpaf_core
// Micro-programmed sequencer around a scratch memory, one shared multiplier and a divider.
// ----------------------------------------------------------------------------
module kpaf_core
    import kpaf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  in_item_t     item,
    input  cfg_array_t   cfg,
    input  logic         out_free,
    output core_status_t status,
    output out_item_t    result
);

    localparam int HSQ_W = 2 * FRAC_BITS + 1;
    localparam logic [3:0] INIT_LAST_WARM = 4'd3;
    localparam logic [3:0] INIT_LAST_COLD = 4'd12;

    core_state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [3:0] cnt_reg, cnt_next;
    logic started_reg, started_next;
    logic flag_reg, flag_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [DATA_W-1:0] zp_reg, zp_next;
    logic [DATA_W-1:0] za_reg, za_next;
    logic [FRAC_BITS-1:0] dt_reg, dt_next;
    logic [DATA_W-1:0] est0_reg, est1_reg, est2_reg;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    addr_t raddr;
    addr_t waddr;
    logic [DATA_W-1:0] wdata;
    logic we;

    uop_t u;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] rd_ext;
    logic signed [ACC_W-1:0] fm_ext;
    logic [HSQ_W-1:0] hsq;
    logic done;
    logic div_start;
    logic div_done;
    logic [DATA_W-1:0] div_q;

    function automatic logic [DATA_W-1:0] sat_u(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? 32'h7FFF_FFFF : v;
    endfunction

    kpaf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (rd_data_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        u = prog(pc_reg);
        base = u.clr ? '0 : acc_reg;
        rd_ext = {{(ACC_W - DATA_W){rd_data_reg[DATA_W-1]}}, rd_data_reg};
        fm_ext = {{(ACC_W - DATA_W){1'b0}}, fx_round(prod_reg)};
        fm_ext = {{(ACC_W - DATA_W){fm_ext[DATA_W-1]}}, fm_ext[DATA_W-1:0]};
        hsq = HSQ_W'(dt_reg) * HSQ_W'(dt_reg) + (HSQ_W'(1) << FRAC_BITS);

        state_next   = state_reg;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        flag_next    = flag_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        prod_next    = prod_reg;
        zp_next      = zp_reg;
        za_next      = za_reg;
        dt_next      = dt_reg;
        we           = 1'b0;
        waddr        = u.d[ADDR_W-1:0];
        wdata        = sat_acc(acc_reg);
        raddr        = u.a;
        div_start    = 1'b0;
        done         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    zp_next    = item.meas_position;
                    za_next    = item.meas_accel;
                    dt_next    = FRAC_BITS'({item.time_step, {FRAC_BITS{1'b0}}} >> 16);
                    flag_next  = 1'b0;
                    cnt_next   = '0;
                    pc_next    = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                // Load the step inputs; on the first item also the initial state.
                we = 1'b1;
                case (cnt_reg)
                    4'd0:    begin waddr = A_DT;  wdata = DATA_W'(dt_reg); end
                    4'd1:    begin waddr = A_H;   wdata = DATA_W'(hsq >> (FRAC_BITS + 1)); end
                    4'd2:    begin waddr = A_ZP;  wdata = zp_reg; end
                    4'd3:    begin waddr = A_ZA;  wdata = za_reg; end
                    4'd4:    begin waddr = A_S0;  wdata = '0; end
                    4'd5:    begin waddr = A_S1;  wdata = '0; end
                    4'd6:    begin waddr = A_S2;  wdata = '0; end
                    4'd7:    begin waddr = A_P00; wdata = sat_u(cfg[CFG_P0_POS]); end
                    4'd8:    begin waddr = A_P01; wdata = '0; end
                    4'd9:    begin waddr = A_P02; wdata = '0; end
                    4'd10:   begin waddr = A_P11; wdata = sat_u(cfg[CFG_P0_VEL]); end
                    4'd11:   begin waddr = A_P12; wdata = '0; end
                    default: begin waddr = A_P22; wdata = sat_u(cfg[CFG_P0_ACC]); end
                endcase
                cnt_next = cnt_reg + 4'd1;
                if ((started_reg && cnt_reg == INIT_LAST_WARM) || cnt_reg == INIT_LAST_COLD)
                begin
                    started_next = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                case (u.op)
                    OP_ST:
                    begin
                        we      = 1'b1;
                        pc_next = pc_reg + 8'd1;
                    end
                    OP_ADDC:
                    begin
                        acc_next = base + {{(ACC_W - DATA_W){1'b0}}, cfg[u.a[2:0]]};
                        pc_next  = pc_reg + 8'd1;
                    end
                    OP_END:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_OPA;
                    end
                endcase
            end
            S_OPA:
            begin
                raddr  = u.b;
                a_next = rd_data_reg;
                case (u.op)
                    OP_ADD:
                    begin
                        acc_next   = base + rd_ext;
                        pc_next    = pc_reg + 8'd1;
                        state_next = S_FETCH;
                    end
                    OP_SUB:
                    begin
                        acc_next   = base - rd_ext;
                        pc_next    = pc_reg + 8'd1;
                        state_next = S_FETCH;
                    end
                    OP_BZ:
                    begin
                        if (rd_data_reg == '0)
                        begin
                            flag_next = 1'b1;
                            pc_next   = u.d;
                        end
                        else
                        begin
                            pc_next = pc_reg + 8'd1;
                        end
                        state_next = S_FETCH;
                    end
                    default:
                    begin
                        state_next = S_OPB;
                    end
                endcase
            end
            S_OPB:
            begin
                if (u.op == OP_DIV)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    prod_next  = a_reg * $signed(rd_data_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next   = (u.op == OP_MSB) ? (base - fm_ext) : (base + fm_ext);
                pc_next    = pc_reg + 8'd1;
                state_next = S_FETCH;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    we         = 1'b1;
                    wdata      = div_q;
                    pc_next    = pc_reg + 8'd1;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            flag_reg    <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        zp_reg   <= zp_next;
        za_reg   <= za_next;
        dt_reg   <= dt_next;
        // The estimates shadow every write to the state vector entries.
        if (we && waddr == A_S0)
        begin
            est0_reg <= wdata;
        end
        if (we && waddr == A_S1)
        begin
            est1_reg <= wdata;
        end
        if (we && waddr == A_S2)
        begin
            est2_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = done;

    assign result.est_position  = est0_reg;
    assign result.est_velocity  = est1_reg;
    assign result.est_accel     = est2_reg;
    assign result.singular_flag = flag_reg;

endmodule

@@ rtl/kpaf_checker.sv @@
// ----------------------------------------------------------------------------
// kpaf_assert
// Port-level assertions for the fusion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "kalman_position_accel_fusion_unit_macros.svh"

module kpaf_assert
    import kpaf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // A stalled result must stay offered and unchanged.
    `KPAF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `KPAF_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
    // A step is not finished at acceptance, so the input side must close right after a transaction.
    `KPAF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled during step")
    // Configuration writes are never refused.
    `KPAF_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind kalman_position_accel_fusion_unit kpaf_assert u_kpaf_assert (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ tb/kpaf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kpaf_checker
// Watches the input, output and configuration channels of the fusion unit,
// runs its own fixed point filter on every accepted input transaction and
// compares each output transaction with the oldest predicted estimate.
// ----------------------------------------------------------------------------
module kpaf_checker
    import kpaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   est_count,
    output int                   sing_count
);

    logic [DATA_W-1:0] regs [NUM_CFG];
    longint            sv_est [3];
    longint            cov [6];
    bit                loaded;
    out_item_t         est_queue [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Product rounded half up to the fraction width, then saturated.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic int cidx(input int r, input int c);
        int lo;
        int hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        if (lo == 0) return hi;
        if (lo == 1) return hi + 2;
        return 5;
    endfunction

    function automatic out_item_t predict_step(input in_item_t it);
        longint dt;
        longint hsq;
        longint phi [3][3];
        longint xp [3];
        longint am [3][3];
        longint pp [3][3];
        longint acc;
        longint s00;
        longint s01;
        longint s11;
        longint det;
        longint in0;
        longint in1;
        longint k0 [3];
        longint k1 [3];
        longint n0;
        longint n1;
        longint qd [3];
        out_item_t r;
        dt = (longint'(it.time_step) << FRAC_BITS) >> 16;
        hsq = (dt * dt + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
        phi = '{'{64'sd1 <<< FRAC_BITS, dt, hsq}, '{0, 64'sd1 <<< FRAC_BITS, dt},
                '{0, 0, 64'sd1 <<< FRAC_BITS}};
        qd[0] = regs[CFG_Q_POS];
        qd[1] = regs[CFG_Q_VEL];
        qd[2] = regs[CFG_Q_ACC];
        if (!loaded) begin
            cov[0] = clamp32(regs[CFG_P0_POS]);
            cov[1] = 0;
            cov[2] = 0;
            cov[3] = clamp32(regs[CFG_P0_VEL]);
            cov[4] = 0;
            cov[5] = clamp32(regs[CFG_P0_ACC]);
            loaded = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += qmul(phi[i][k], sv_est[k]);
            xp[i] = clamp32(acc);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += qmul(phi[i][k], cov[cidx(k, j)]);
                am[i][j] = clamp32(acc);
            end
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++) begin
                acc = (i == j) ? qd[i] : 0;
                for (int k = 0; k < 3; k++) acc += qmul(am[i][k], phi[j][k]);
                pp[i][j] = clamp32(acc);
                pp[j][i] = pp[i][j];
            end
        s00 = clamp32(pp[0][0] + longint'(regs[CFG_R_POS]));
        s01 = pp[0][2];
        s11 = clamp32(pp[2][2] + longint'(regs[CFG_R_ACC]));
        det = clamp32(qmul(s00, s11) - qmul(s01, s01));
        r.singular_flag = (det == 0);
        if (det == 0) begin
            for (int i = 0; i < 3; i++) sv_est[i] = xp[i];
            for (int i = 0; i < 3; i++)
                for (int j = i; j < 3; j++) cov[cidx(i, j)] = pp[i][j];
        end else begin
            in0 = clamp32(longint'(it.meas_position) - xp[0]);
            in1 = clamp32(longint'(it.meas_accel) - xp[2]);
            for (int i = 0; i < 3; i++) begin
                n0 = clamp32(qmul(pp[i][0], s11) - qmul(pp[i][2], s01));
                n1 = clamp32(qmul(pp[i][2], s00) - qmul(pp[i][0], s01));
                k0[i] = clamp32((n0 <<< FRAC_BITS) / det);
                k1[i] = clamp32((n1 <<< FRAC_BITS) / det);
            end
            for (int i = 0; i < 3; i++)
                sv_est[i] = clamp32(xp[i] + qmul(k0[i], in0) + qmul(k1[i], in1));
            for (int i = 0; i < 3; i++)
                for (int j = i; j < 3; j++)
                    cov[cidx(i, j)] = clamp32(pp[i][j] - qmul(k0[i], pp[0][j])
                                              - qmul(k1[i], pp[2][j]));
        end
        r.est_position = sv_est[0][31:0];
        r.est_velocity = sv_est[1][31:0];
        r.est_accel    = sv_est[2][31:0];
        return r;
    endfunction

    assign pending = est_queue.size();

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) regs[i] = FX_ONE;
            for (int i = 0; i < 3; i++) sv_est[i] = 0;
            for (int i = 0; i < 6; i++) cov[i] = 0;
            loaded = 1'b0;
            est_queue.delete();
            fail_count <= 0;
            est_count <= 0;
            sing_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_CFG)
                regs[cfg_index[2:0]] = cfg_data;
            if (in_valid && !in_stall)
                est_queue.push_back(predict_step(in_data));
            if (out_valid && !out_stall) begin
                est_count <= est_count + 1;
                if (out_data.singular_flag) sing_count <= sing_count + 1;
                if (est_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = est_queue.pop_front();
                    if (want !== out_data) begin
                        $display("%0t: mismatch expected pos %h vel %h acc %h sing %b",
                                 $time, want.est_position, want.est_velocity,
                                 want.est_accel, want.singular_flag);
                        $display("%0t:          actual   pos %h vel %h acc %h sing %b",
                                 $time, out_data.est_position, out_data.est_velocity,
                                 out_data.est_accel, out_data.singular_flag);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives measurements and register writes into the fusion unit, with bursty
// input traffic and a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import kpaf_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd6000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   est_count;
    int                   sing_count;
    longint               cycles;
    int                   gap_left;
    int                   burst_left;
    int                   stall_mode;

    kalman_position_accel_fusion_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    kpaf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending),
        .est_count (est_count),
        .sing_count(sing_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results pending", cycles, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // The receiver switches at random between four stall behaviors.
    initial
    begin
        out_stall = 1'b0;
        stall_mode = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 399) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Sends one measurement; the sender may idle between bursts.
    task automatic send_meas(input logic [31:0] pos, input logic [31:0] acc,
                             input logic [15:0] dt);
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            burst_left = $urandom_range(1, 8);
            repeat (gap_left) @(negedge clk);
        end
        burst_left--;
        in_valid = 1'b1;
        in_data  = '{pos, acc, dt};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (700) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_q(input int bits);
        logic [31:0] v;
        v = $urandom();
        if (bits < 32) v = 32'($signed(v) >>> (32 - bits));
        return v;
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, 32'h0008_0000);
        endcase
    endfunction

    initial
    begin
        logic [31:0] zp;
        logic [31:0] za;
        int          bits;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes with default registers.
        send_meas(32'h0001_0000, 32'h0000_8000, 16'h0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_meas(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_meas(32'hFFFF_FFFF, 32'h0000_0000, 16'h8000);
        send_meas(32'h0000_0000, 32'hFFFF_FFFF, 16'h0001);
        send_meas(32'h5555_AAAA, 32'hAAAA_5555, 16'h5A5A);
        drain();

        // Zero noise and zero initial covariance registers, then two measurements.
        for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), 32'd0);
        write_reg(CFG_IDX_W'(NUM_CFG + 3), 32'h1234_5678);
        send_meas(32'h0010_0000, 32'h0002_0000, 16'h1000);
        send_meas(32'hFFF0_0000, 32'hFFFE_0000, 16'hFFFF);
        drain();

        // Register maxima: saturation of every sum involving a register.
        for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), 32'hFFFF_FFFF);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_meas(32'h8000_0000, 32'h8000_0000, 16'h0000);
        send_meas(32'h0000_0001, 32'hFFFF_FFFE, 16'h0100);
        drain();

        for (int p = 0; p < 16; p++)
        begin
            for (int i = 0; i < NUM_CFG; i++)
                write_reg(CFG_IDX_W'(i), (p < 2) ? 32'h0001_0000 : rand_reg());
            bits = $urandom_range(18, 32);
            for (int n = 0; n < 100; n++)
            begin
                // Mostly a smooth trajectory, sometimes a wild sample.
                if ($urandom_range(0, 9) == 0)
                begin
                    zp = $urandom();
                    za = $urandom();
                end
                else
                begin
                    zp = rand_q(bits);
                    za = rand_q(bits - 2);
                end
                send_meas(zp, za, ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                           : 16'($urandom_range(0, 2000)));
            end
            drain();
        end

        $display("Checked %0d estimates (%0d singular) over 19 register settings.",
                 est_count, sing_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kpaf_pkg.sv
rtl/kpaf_regs.sv
rtl/kpaf_div.sv
rtl/kpaf_core.sv
rtl/kalman_position_accel_fusion_unit.sv
rtl/kpaf_checker.sv
tb/kpaf_checker.sv
tb/testbench.sv
